### rtl/fvn_pkg.sv
// Shared constants and types for the fractal value noise core.
package fvn_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W       = 64;
    localparam int OUT_W      = 24;
    localparam int NOISE_W    = 18;
    localparam int COORD_W    = 32;
    localparam int FREQ_W     = 64;
    localparam int AMP_W      = 43;
    localparam int SEED_W     = 32;
    localparam int OCT_W      = 4;
    localparam int LAC_W      = 24;
    localparam int GAIN_W     = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_BITS   = 17;

    localparam logic [FREQ_W-1:0] ONE_FREQ = FREQ_W'(1) << FRAC_BITS;
    localparam logic [AMP_W-1:0]  ONE_AMP  = AMP_W'(1) << FRAC_BITS;
    localparam logic [AMP_W-1:0]  AMP_CAP  = AMP_W'(1) << (58 - FRAC_BITS);

    localparam logic [LAC_W-1:0]  RIDGE_LAC  = LAC_W'(2) << FRAC_BITS;
    localparam logic [GAIN_W-1:0] RIDGE_GAIN = GAIN_W'(1) << (FRAC_BITS - 1);

    localparam logic [SEED_W-1:0] FBM_SEED_STEP   = 32'd1013;
    localparam logic [SEED_W-1:0] RIDGE_SEED_STEP = 32'd7919;

    localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;
    localparam logic [31:0] HASH_MX     = 32'h85ebca6b;
    localparam logic [31:0] HASH_MZ     = 32'hc2b2ae35;
    localparam logic [31:0] HASH_MUL    = 32'h27d4eb2f;

    // Reset values of the configuration registers
    localparam logic [SEED_W-1:0] RST_SEED    = '0;
    localparam logic [OCT_W-1:0]  RST_OCTAVES = 4'd4;
    localparam logic [LAC_W-1:0]  RST_LAC     = 24'd131072;
    localparam logic [GAIN_W-1:0] RST_GAIN    = 20'd32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SEED      = 3'd0,
        CFG_OCTAVES   = 3'd1,
        CFG_LACUNARITY = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_MODE      = 3'd4
    } cfg_idx_t;

endpackage

### rtl/fractal_value_noise_2d_core.sv
// Throughput: one item per cycle while the output is not stalled and no table rebuild runs;
// every stage holds its own valid bit and bubbles collapse. The per-octave frequency,
// amplitude and seed tables are rebuilt by a sequencer (SEQ_START, then SEQ_LO, SEQ_HI and
// SEQ_SUM per octave) after reset and after every configuration write; s_tready stays low
// meanwhile. Reset is asynchronous, active low, and restores the default configuration
// (seed 0, 4 octaves, lacunarity 2.0, gain 0.5, fbm mode).
module fractal_value_noise_2d_core #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] x_pos, [63:32] z_pos
    input  logic [fvn_pkg::IN_W-1:0]              s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [17:0] noise_value, [23:18] zero
    output logic [fvn_pkg::OUT_W-1:0]             m_tdata,
    input  logic                                  cfg_we,
    input  logic [fvn_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import fvn_pkg::*;

    typedef enum logic [2:0] {
        SEQ_START,
        SEQ_LO,
        SEQ_HI,
        SEQ_SUM,
        SEQ_IDLE
    } seq_state_t;

    localparam int IDX_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int NORM_W = AMP_W + $clog2(MAX_OCTAVES) + 1;
    localparam int NPAIR  = (MAX_OCTAVES + 1) / 2;
    localparam int ST_PAIR = 9;
    localparam int ST_SUM  = 10;
    localparam int ST_DIV  = 11;
    localparam int NS      = ST_DIV + DIV_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SEED_W-1:0] seed_value_reg;
    logic [OCT_W-1:0]  octave_count_reg;
    logic [LAC_W-1:0]  lacunarity_reg;
    logic [GAIN_W-1:0] gain_factor_reg;
    logic              noise_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg   <= RST_SEED;
            octave_count_reg <= RST_OCTAVES;
            lacunarity_reg   <= RST_LAC;
            gain_factor_reg  <= RST_GAIN;
            noise_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SEED:       seed_value_reg   <= cfg_data[SEED_W-1:0];
                CFG_OCTAVES:    octave_count_reg <= cfg_data[OCT_W-1:0];
                CFG_LACUNARITY: lacunarity_reg   <= cfg_data[LAC_W-1:0];
                CFG_GAIN:       gain_factor_reg  <= cfg_data[GAIN_W-1:0];
                CFG_MODE:       noise_mode_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Octave table sequencer
    // ------------------------------------------------------------------
    seq_state_t        seq_state_reg;
    logic [IDX_W-1:0]  oct_reg;
    logic              busy;

    logic [FREQ_W-1:0] freq_tab_reg [MAX_OCTAVES];
    logic [AMP_W-1:0]  amp_tab_reg  [MAX_OCTAVES];
    logic [SEED_W-1:0] seed_tab_reg [MAX_OCTAVES];
    logic [NORM_W-1:0] norm_reg;

    logic [FREQ_W-1:0] freq_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [SEED_W-1:0] seed_acc_reg;
    logic [55:0]       plo_reg;
    logic [55:0]       phi_reg;
    logic [51:0]       alo_reg;
    logic [30:0]       ahi_reg;

    logic [LAC_W-1:0]  lac_eff;
    logic [GAIN_W-1:0] gain_eff;
    logic [SEED_W-1:0] seed_step;
    logic              oct_active;
    logic [AMP_W-1:0]  amp_eff;
    logic [87:0]       freq_prod;
    logic [63:0]       amp_prod;
    logic [FREQ_W-1:0] freq_next;
    logic [AMP_W-1:0]  amp_next;

    always_comb
    begin
        lac_eff    = noise_mode_reg ? RIDGE_LAC : lacunarity_reg;
        gain_eff   = noise_mode_reg ? RIDGE_GAIN : gain_factor_reg;
        seed_step  = noise_mode_reg ? RIDGE_SEED_STEP : FBM_SEED_STEP;
        // octave count of zero still runs the first octave
        oct_active = (oct_reg == '0) || (5'(oct_reg) < 5'(octave_count_reg));
        amp_eff    = oct_active ? amp_reg : '0;
        freq_prod  = 88'(plo_reg) + (88'(phi_reg) << 32);
        freq_next  = freq_prod[FRAC_BITS+FREQ_W-1:FRAC_BITS];
        amp_prod   = 64'(alo_reg) + (64'(ahi_reg) << 32);
        amp_next   = (amp_prod[63:FRAC_BITS] > 48'(AMP_CAP)) ? AMP_CAP
                                                             : amp_prod[FRAC_BITS+AMP_W-1:FRAC_BITS];
        busy       = (seq_state_reg != SEQ_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_START;
            oct_reg       <= '0;
        end
        else if (cfg_we)
        begin
            seq_state_reg <= SEQ_START;
        end
        else
        begin
            unique case (seq_state_reg)
                SEQ_START:
                begin
                    oct_reg       <= '0;
                    seq_state_reg <= SEQ_LO;
                end
                SEQ_LO:  seq_state_reg <= SEQ_HI;
                SEQ_HI:  seq_state_reg <= SEQ_SUM;
                SEQ_SUM:
                begin
                    if (oct_reg == IDX_W'(MAX_OCTAVES - 1))
                    begin
                        seq_state_reg <= SEQ_IDLE;
                    end
                    else
                    begin
                        oct_reg       <= oct_reg + 1'b1;
                        seq_state_reg <= SEQ_LO;
                    end
                end
                SEQ_IDLE: ;
                default:  seq_state_reg <= SEQ_START;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (seq_state_reg)
            SEQ_START:
            begin
                freq_reg     <= ONE_FREQ;
                amp_reg      <= ONE_AMP;
                seed_acc_reg <= seed_value_reg;
                norm_reg     <= '0;
            end
            SEQ_LO:
            begin
                freq_tab_reg[oct_reg] <= freq_reg;
                amp_tab_reg[oct_reg]  <= amp_eff;
                seed_tab_reg[oct_reg] <= seed_acc_reg;
                norm_reg              <= norm_reg + NORM_W'(amp_eff);
                plo_reg               <= 56'(freq_reg[31:0]) * 56'(lac_eff);
                alo_reg               <= 52'(amp_reg[31:0]) * 52'(gain_eff);
            end
            SEQ_HI:
            begin
                phi_reg <= 56'(freq_reg[63:32]) * 56'(lac_eff);
                ahi_reg <= 31'(amp_reg[AMP_W-1:32]) * 31'(gain_eff);
            end
            SEQ_SUM:
            begin
                freq_reg     <= freq_next;
                amp_reg      <= amp_next;
                seed_acc_reg <= seed_acc_reg + seed_step;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: per-stage valid, bubbles collapse
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic          in_acc;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0] && !busy;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_acc;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Octave lanes
    // ------------------------------------------------------------------
    logic signed [63:0] term_w [MAX_OCTAVES];

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
        logic signed [64:0] xa_full, za_full;
        logic [63:0]        xa_q, za_q;
        logic [31:0]        xb_q, zb_q;
        logic [63:0]        xlo, zlo;
        logic [31:0]        cx_q, cz_q;
        logic [15:0]        fx_q, fz_q;
        logic [31:0]        sqx, sqz;
        logic [31:0]        xm_q, zm_q;
        logic [15:0]        ttx_q, ttz_q, fx2_q, fz2_q;
        logic [31:0]        cbx, cbz;
        logic [19:0]        dmx, dmz;
        logic [35:0]        dpx, dpz;
        logic [31:0]        hash_mix [4];
        logic [31:0]        hm_q [4];
        logic [15:0]        t3x_q, t3z_q;
        logic [19:0]        dx_q, dz_q;
        logic [31:0]        hfin [4];
        logic [35:0]        fpx, fpz;
        logic signed [17:0] cv_q [4];
        logic [16:0]        tx_q, tz_q;
        logic signed [18:0] dra, drb, dn;
        logic signed [36:0] pra, prb, pn;
        logic signed [17:0] ra_q, rb_q;
        logic [16:0]        tz2_q;
        logic signed [17:0] n_q;
        logic [17:0]        nabs, rgap;
        logic [35:0]        rsq;
        logic signed [17:0] v_q;
        logic signed [63:0] term_q;

        always_comb
        begin
            xa_full = $signed(s_tdata[31:0]) * $signed({1'b0, freq_tab_reg[o][31:0]});
            za_full = $signed(s_tdata[63:32]) * $signed({1'b0, freq_tab_reg[o][31:0]});
            xlo     = xa_q + {xb_q, 32'h0};
            zlo     = za_q + {zb_q, 32'h0};
            sqx     = 32'(fx_q) * 32'(fx_q);
            sqz     = 32'(fz_q) * 32'(fz_q);
            cbx     = 32'(ttx_q) * 32'(fx2_q);
            cbz     = 32'(ttz_q) * 32'(fz2_q);
            dmx     = 20'd983040 - 20'(fx2_q) * 20'd6;
            dmz     = 20'd983040 - 20'(fz2_q) * 20'd6;
            dpx     = 36'(dmx) * 36'(fx2_q);
            dpz     = 36'(dmz) * 36'(fz2_q);
            // corner c: bit 0 steps x, bit 1 steps z
            for (int c = 0; c < 4; c++)
            begin
                logic [31:0] g0;
                logic [31:0] g1;
                g0 = (seed_tab_reg[o] + HASH_GOLDEN) ^ (xm_q + (c[0] ? HASH_MX : 32'h0));
                g1 = {g0[18:0], g0[31:19]};
                hash_mix[c] = g1 ^ (zm_q + (c[1] ? HASH_MZ : 32'h0));
                hfin[c]     = hm_q[c] ^ (hm_q[c] >> 15);
            end
            fpx  = 36'(t3x_q) * 36'(20'd655360 - dx_q);
            fpz  = 36'(t3z_q) * 36'(20'd655360 - dz_q);
            dra  = 19'(cv_q[1]) - 19'(cv_q[0]);
            drb  = 19'(cv_q[3]) - 19'(cv_q[2]);
            pra  = dra * $signed({1'b0, tx_q});
            prb  = drb * $signed({1'b0, tx_q});
            dn   = 19'(rb_q) - 19'(ra_q);
            pn   = dn * $signed({1'b0, tz2_q});
            nabs = n_q[17] ? 18'(-n_q) : 18'(n_q);
            rgap = 18'd65536 - nabs;
            rsq  = 36'(rgap) * 36'(rgap);
        end

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                xa_q <= xa_full[63:0];
                za_q <= za_full[63:0];
                xb_q <= s_tdata[31:0] * freq_tab_reg[o][63:32];
                zb_q <= s_tdata[63:32] * freq_tab_reg[o][63:32];
            end
            if (en[1])
            begin
                cx_q <= xlo[63:32];
                cz_q <= zlo[63:32];
                fx_q <= xlo[31:16];
                fz_q <= zlo[31:16];
            end
            if (en[2])
            begin
                xm_q  <= cx_q * HASH_MX;
                zm_q  <= cz_q * HASH_MZ;
                ttx_q <= sqx[31:16];
                ttz_q <= sqz[31:16];
                fx2_q <= fx_q;
                fz2_q <= fz_q;
            end
            if (en[3])
            begin
                for (int c = 0; c < 4; c++)
                begin
                    hm_q[c] <= hash_mix[c] * HASH_MUL;
                end
                t3x_q <= cbx[31:16];
                t3z_q <= cbz[31:16];
                dx_q  <= dpx[35:16];
                dz_q  <= dpz[35:16];
            end
            if (en[4])
            begin
                for (int c = 0; c < 4; c++)
                begin
                    cv_q[c] <= $signed({1'b0, hfin[c][31:15]}) - 18'sd65536;
                end
                tx_q <= fpx[32:16];
                tz_q <= fpz[32:16];
            end
            if (en[5])
            begin
                ra_q  <= cv_q[0] + pra[33:16];
                rb_q  <= cv_q[2] + prb[33:16];
                tz2_q <= tz_q;
            end
            if (en[6])
            begin
                n_q <= ra_q + pn[33:16];
            end
            if (en[7])
            begin
                v_q <= noise_mode_reg ? $signed(rsq[33:16]) : n_q;
            end
            if (en[8])
            begin
                term_q <= $signed({1'b0, amp_tab_reg[o]}) * v_q;
            end
        end

        assign term_w[o] = term_q;
    end

    // ------------------------------------------------------------------
    // Octave sum
    // ------------------------------------------------------------------
    logic signed [63:0] pair_sum [NPAIR];
    logic signed [63:0] pair_q   [NPAIR];
    logic signed [63:0] total;

    always_comb
    begin
        for (int k = 0; k < NPAIR; k++)
        begin
            pair_sum[k] = term_w[2*k];
            if (2*k + 1 < MAX_OCTAVES)
            begin
                pair_sum[k] = pair_sum[k] + term_w[2*k+1];
            end
        end
        total = '0;
        for (int k = 0; k < NPAIR; k++)
        begin
            total = total + pair_q[k];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [63:0]          rem_q [DIV_BITS+1];
    logic [DIV_BITS-1:0]  quo_q [DIV_BITS+1];
    logic                 sgn_q [DIV_BITS+1];
    logic [63:0]          dvs   [DIV_BITS];
    logic                 qbit  [DIV_BITS];
    logic [NOISE_W-1:0]   quo_ext;
    logic [NOISE_W-1:0]   noise_reg;

    always_comb
    begin
        for (int k = 0; k < DIV_BITS; k++)
        begin
            dvs[k]  = 64'(norm_reg) << (DIV_BITS - 1 - k);
            qbit[k] = (rem_q[k] >= dvs[k]);
        end
        quo_ext = NOISE_W'(quo_q[DIV_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PAIR])
        begin
            pair_q <= pair_sum;
        end
        if (en[ST_SUM])
        begin
            sgn_q[0] <= total[63];
            rem_q[0] <= total[63] ? 64'(-total) : 64'(total);
            quo_q[0] <= '0;
        end
        for (int k = 0; k < DIV_BITS; k++)
        begin
            if (en[ST_DIV+k])
            begin
                sgn_q[k+1] <= sgn_q[k];
                rem_q[k+1] <= qbit[k] ? rem_q[k] - dvs[k] : rem_q[k];
                quo_q[k+1] <= {quo_q[k][DIV_BITS-2:0], qbit[k]};
            end
        end
        // truncate toward zero: divide magnitudes, then restore the sign
        if (en[NS-1])
        begin
            noise_reg <= sgn_q[DIV_BITS] ? -quo_ext : quo_ext;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {{(OUT_W - NOISE_W){1'b0}}, noise_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("item accepted while octave tables rebuild");

    a_cfg_restarts_tables: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("configuration write did not restart table build");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (norm_reg >= NORM_W'(ONE_AMP)))
        else $error("amplitude total below one");

    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[NOISE_W-1:0]) >= -18'sd65536 &&
                      $signed(m_tdata[NOISE_W-1:0]) <= 18'sd65536))
        else $error("noise value out of range");

    a_ridged_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && noise_mode_reg && !busy) |-> !m_tdata[NOISE_W-1])
        else $error("ridged noise negative");

endmodule

### verif/fractal_value_noise_2d_checker.sv
// Checker for the fractal value noise core: watches the streams, predicts and compares.
`timescale 1ns / 100ps
module fractal_value_noise_2d_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [fvn_pkg::IN_W-1:0]       s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fvn_pkg::OUT_W-1:0]      m_tdata,
    input  logic                           cfg_we,
    input  logic [fvn_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import fvn_pkg::*;

    logic [SEED_W-1:0] seed_reg;
    logic [OCT_W-1:0]  octave_reg;
    logic [LAC_W-1:0]  lac_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              mode_reg;

    logic [OUT_W-1:0]  noise_queue [$];
    int                mismatches;

    function automatic logic [31:0] cell_mix(input logic [31:0] cx, input logic [31:0] cz,
                                             input logic [31:0] sd);
        logic [31:0] h;
        h = sd + HASH_GOLDEN;
        h = h ^ (cx * HASH_MX);
        h = {h[18:0], h[31:19]};
        h = h ^ (cz * HASH_MZ);
        h = h * HASH_MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    function automatic longint corner_level(input logic [31:0] cx, input logic [31:0] cz,
                                            input logic [31:0] sd);
        logic [31:0] h;
        h = cell_mix(cx, cz, sd);
        return longint'({47'b0, h[31:15]}) - 64'sd65536;
    endfunction

    function automatic logic [63:0] fade_of(input logic [15:0] t);
        logic [63:0] tt;
        logic [63:0] t3;
        logic [63:0] d;
        tt = {48'b0, t};
        t3 = (((tt * tt) >> 16) * tt) >> 16;
        d  = ((64'd983040 - 64'd6 * tt) * tt) >> 16;
        return (t3 * (64'd655360 - d)) >> 16;
    endfunction

    function automatic longint mix(input longint a, input longint b, input logic [63:0] t);
        longint prod;
        prod = (b - a) * longint'(t);
        return a + (prod >>> 16);
    endfunction

    function automatic longint octave_value(input logic [31:0] x, input logic [31:0] z,
                                            input logic [63:0] freq, input logic [31:0] sd);
        logic signed [127:0] px;
        logic signed [127:0] pz;
        logic [31:0]         cx;
        logic [31:0]         cz;
        logic [63:0]         tx;
        logic [63:0]         tz;
        longint              top;
        longint              bot;
        px  = $signed({{96{x[31]}}, x}) * $signed({64'b0, freq});
        pz  = $signed({{96{z[31]}}, z}) * $signed({64'b0, freq});
        cx  = px[63:32];
        cz  = pz[63:32];
        tx  = fade_of(px[31:16]);
        tz  = fade_of(pz[31:16]);
        top = mix(corner_level(cx, cz, sd), corner_level(cx + 1, cz, sd), tx);
        bot = mix(corner_level(cx, cz + 1, sd), corner_level(cx + 1, cz + 1, sd), tx);
        return mix(top, bot, tz);
    endfunction

    function automatic logic [OUT_W-1:0] noise_predict(input logic [31:0] x,
                                                       input logic [31:0] z);
        int           octs;
        logic [63:0]  lac;
        logic [63:0]  gain;
        logic [31:0]  step;
        logic [63:0]  freq;
        logic [63:0]  amp;
        logic [63:0]  norm;
        logic [127:0] fprod;
        longint       sum;
        longint       n;
        longint       r;
        longint       quot;
        octs = (octave_reg == 0) ? 1 : ((octave_reg > 8) ? 8 : int'(octave_reg));
        lac  = mode_reg ? 64'd131072 : {40'b0, lac_reg};
        gain = mode_reg ? 64'd32768 : {44'b0, gain_reg};
        step = mode_reg ? RIDGE_SEED_STEP : FBM_SEED_STEP;
        freq = 64'd65536;
        amp  = 64'd65536;
        norm = '0;
        sum  = 0;
        for (int o = 0; o < octs; o++)
        begin
            n = octave_value(x, z, freq, seed_reg + 32'(o) * step);
            if (mode_reg)
            begin
                r = 64'sd65536 - ((n < 0) ? -n : n);
                n = (r * r) >>> 16;
            end
            sum  = sum + longint'(amp) * n;
            norm = norm + amp;
            amp  = (amp * gain) >> 16;
            if (amp > 64'(AMP_CAP))
                amp = 64'(AMP_CAP);
            fprod = {64'b0, freq} * {64'b0, lac};
            freq  = fprod[79:16];
        end
        quot = sum / longint'(norm);
        return {6'b0, quot[17:0]};
    endfunction

    assign pending = noise_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= RST_SEED;
            octave_reg <= RST_OCTAVES;
            lac_reg    <= RST_LAC;
            gain_reg   <= RST_GAIN;
            mode_reg   <= 1'b0;
            fail_count <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                noise_queue.push_back(noise_predict(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                if (noise_queue.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected noise item %h", m_tdata);
                    mismatches <= mismatches + 1;
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (m_tdata !== noise_queue[0])
                    begin
                        if (mismatches < 10)
                            $display("noise mismatch: expected %h actual %h",
                                     noise_queue[0], m_tdata);
                        mismatches <= mismatches + 1;
                        fail_count <= fail_count + 1;
                    end
                    void'(noise_queue.pop_front());
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_SEED:       seed_reg   <= cfg_data;
                    CFG_OCTAVES:    octave_reg <= cfg_data[OCT_W-1:0];
                    CFG_LACUNARITY: lac_reg    <= cfg_data[LAC_W-1:0];
                    CFG_GAIN:       gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_MODE:       mode_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

### verif/fractal_value_noise_2d_core_tb.sv
// Testbench top for the fractal value noise core: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module fractal_value_noise_2d_core_tb;
    import fvn_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   fail_count;
    int   pending;
    logic rx_took = 1'b0;
    int   rx_stall = 0;
    bit   burst = 0;

    fractal_value_noise_2d_core DUT (.*);

    fractal_value_noise_2d_checker noise_check (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        rx_took <= m_tvalid && m_tready;

    // Draw a fresh stall after every taken item
    always @(negedge clk)
    begin
        if (rx_took)
            rx_stall = burst ? 0 : $urandom_range(0, 13);
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] z);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {z, x};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Drain all results before touching the registers
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (35) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            2:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ((i % 20) == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_point(rand_coord(), rand_coord());
        end
        burst = 0;
    endtask

    initial
    begin
        logic [31:0] edges [8];
        edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                  32'h1, 32'h00010000, 32'hffff0000, 32'h0000ffff};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Field extremes under the reset configuration
        for (int i = 0; i < 8; i++)
            send_point(edges[i], edges[7 - i]);
        send_point(32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000);
        random_points(40);
        // Zero octaves, then more than allowed
        write_reg(CFG_OCTAVES, 32'd0);
        for (int i = 0; i < 4; i++)
            send_point(edges[i], edges[i + 4]);
        random_points(50);
        write_reg(CFG_OCTAVES, 32'd15);
        random_points(50);
        // Frequency wrap with the largest lacunarity
        write_reg(CFG_LACUNARITY, 32'hffffff);
        send_point(32'h7fffffff, 32'h80000000);
        random_points(50);
        write_reg(CFG_LACUNARITY, 32'd0);
        random_points(40);
        // Zero gain, then amplitude saturation
        write_reg(CFG_GAIN, 32'd0);
        random_points(40);
        write_reg(CFG_LACUNARITY, 32'd131072);
        write_reg(CFG_GAIN, 32'hfffff);
        random_points(50);
        write_reg(CFG_SEED, 32'hffffffff);
        random_points(50);
        write_reg(CFG_MODE, 32'd1);
        write_reg(CFG_OCTAVES, 32'd8);
        for (int i = 0; i < 4; i++)
            send_point(edges[i], edges[i]);
        random_points(50);
        write_reg(CFG_OCTAVES, 32'd1);
        random_points(40);
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_SEED, $urandom());
            write_reg(CFG_OCTAVES, $urandom_range(0, 15));
            write_reg(CFG_LACUNARITY, $urandom_range(0, 24'hffffff));
            write_reg(CFG_GAIN, $urandom_range(0, 20'hfffff));
            write_reg(CFG_MODE, $urandom_range(0, 1));
            random_points(55);
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
